>>> rtl/psm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psm_pkg
// Shared types, constants and the sine table builder of the tone mixer.
// ----------------------------------------------------------------------------
package psm_pkg;

  localparam int SR_W     = 18;
  localparam int FREQ_W   = 15;
  localparam int VOL_W    = 16;
  localparam int DUR_W    = 16;
  localparam int SAMPLE_W = 16;
  localparam int PER_W    = 18;
  localparam int PROD_W   = DUR_W + SR_W;
  localparam int FRM_W    = 25;
  localparam int REMAIN_W = 26;
  localparam int DIV_W    = 34;
  localparam int DIV_CW   = 6;
  localparam int QDEPTH   = 2;
  localparam int QAW      = 1;
  localparam int QCW      = 2;

  // divide by 1000 as (x >> 3) * RECIP_125 >> RECIP_SH, exact below 2^PROD_W
  localparam int          MS_SH     = 3;
  localparam int          RECIP_SH  = 38;
  localparam int          FMUL_W    = PROD_W - MS_SH + 32;
  localparam logic [31:0] RECIP_125 = 32'd2199023256;

  localparam logic [SR_W-1:0] SR_RESET = 18'd48000;

  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;

  typedef struct packed {
    logic              play;
    logic [FREQ_W-1:0] freq;
    logic [VOL_W-1:0]  volume;
    logic [DUR_W-1:0]  duration;
  } psm_cmd_t;

  typedef struct packed {
    logic [PER_W-1:0]    period;
    logic [VOL_W-1:0]    volume;
    logic [PER_W-1:0]    phase;
    logic [REMAIN_W-1:0] remain;
  } psm_voice_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  num;
    logic [PER_W-1:0]  den;
  } psm_div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_W-1:0]  quo;
    logic [PER_W-1:0]  rem;
  } psm_div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_P_PER_GO,
    ST_P_PER_W,
    ST_P_MUL,
    ST_P_FRM,
    ST_P_RND_GO,
    ST_P_RND_W,
    ST_P_WR,
    ST_T_RD,
    ST_T_LD,
    ST_T_DIV,
    ST_T_MUL,
    ST_T_ACC,
    ST_OUT
  } psm_state_t;

  function automatic logic [63:0] taylor_div(input int i);
    logic [63:0] d;
    case (i)
      1:       d = 64'd6;
      2:       d = 64'd20;
      3:       d = 64'd42;
      4:       d = 64'd72;
      5:       d = 64'd110;
      6:       d = 64'd156;
      7:       d = 64'd210;
      8:       d = 64'd272;
      default: d = 64'd1;
    endcase
    return d;
  endfunction

  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] sin_q30(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    longint      s;
    x2   = (x * x) >> 30;
    term = x;
    s    = longint'(x);
    for (int i = 1; i <= 8; i++) begin
      term = udiv64((term * x2) >> 30, taylor_div(i));
      if (i % 2 == 1) s = s - longint'(term);
      else s = s + longint'(term);
    end
    if (s < 0) s = 0;
    if (s > longint'(ONE_Q30)) s = longint'(ONE_Q30);
    return 64'(s);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sine_entry(input int k, input int lg);
    logic [63:0] n;
    logic [63:0] a;
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] ang;
    logic [63:0] s;
    logic [63:0] mag;
    n   = 64'd1 << lg;
    a   = 64'(k) * 64'd4;
    q   = a >> lg;
    r   = a & (n - 64'd1);
    if (q[0]) r = n - r;
    ang = (r * PI_Q30) >> (lg + 1);
    s   = sin_q30(ang);
    mag = (s * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
    if (q >= 64'd2) return -SAMPLE_W'(mag);
    return SAMPLE_W'(mag);
  endfunction

endpackage

>>> rtl/psm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psm_req_if / psm_rsp_if
// Valid/ready channels carrying request and response words.
// ----------------------------------------------------------------------------
interface psm_req_if;
  logic                        valid;
  logic                        ready;
  logic                        cmd;
  logic [psm_pkg::FREQ_W-1:0]  frequency;
  logic [psm_pkg::VOL_W-1:0]   volume;
  logic [psm_pkg::DUR_W-1:0]   duration_ms;

  modport source (output valid, cmd, frequency, volume, duration_ms, input ready);
  modport sink   (input valid, cmd, frequency, volume, duration_ms, output ready);
endinterface

interface psm_rsp_if;
  logic                               valid;
  logic                               ready;
  logic signed [psm_pkg::SAMPLE_W-1:0] sample;
  logic                               play_dropped;

  modport source (output valid, sample, play_dropped, input ready);
  modport sink   (input valid, sample, play_dropped, output ready);
endinterface

>>> rtl/psm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psm_front
// Accepts request words, decodes them and queues them for the back end.
// ----------------------------------------------------------------------------
module psm_front (
  input  logic              clk,
  input  logic              rst,
  psm_req_if.sink           req,
  output logic              q_valid,
  output psm_pkg::psm_cmd_t q_data,
  input  logic              q_ready
);

  psm_pkg::psm_cmd_t             fifo [psm_pkg::QDEPTH];
  logic [psm_pkg::QAW-1:0]       wptr;
  logic [psm_pkg::QAW-1:0]       rptr;
  logic [psm_pkg::QCW-1:0]       count;
  logic                          push;
  logic                          pop;
  psm_pkg::psm_cmd_t             dec;

  always_comb begin
    dec.play     = req.cmd;
    dec.freq     = (req.frequency == '0) ? psm_pkg::FREQ_W'(1) : req.frequency;
    dec.volume   = req.volume;
    dec.duration = req.duration_ms;
  end

  assign req.ready = (count != psm_pkg::QCW'(psm_pkg::QDEPTH));
  assign push      = req.valid && req.ready;
  assign q_valid   = (count != '0);
  assign pop       = q_valid && q_ready;
  assign q_data    = fifo[rptr];

  always_ff @(posedge clk) begin
    if (push) fifo[wptr] <= dec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

>>> rtl/psm_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psm_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module psm_div (
  input  logic                  clk,
  input  logic                  rst,
  input  psm_pkg::psm_div_req_t div_req,
  output psm_pkg::psm_div_rsp_t div_rsp
);

  logic [psm_pkg::DIV_W-1:0]  quo;
  logic [psm_pkg::PER_W-1:0]  rem;
  logic [psm_pkg::PER_W-1:0]  den;
  logic [psm_pkg::DIV_CW-1:0] cnt;
  logic                       busy;
  logic                       done;
  logic [psm_pkg::PER_W:0]    trial;
  logic                       fits;

  assign trial = {rem, quo[psm_pkg::DIV_W-1]};
  assign fits  = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (div_req.start) begin
      quo <= div_req.num;
      rem <= '0;
      den <= div_req.den;
    end else if (busy) begin
      rem <= fits ? psm_pkg::PER_W'(trial - {1'b0, den}) : psm_pkg::PER_W'(trial);
      quo <= {quo[psm_pkg::DIV_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (div_req.start) begin
        busy <= 1'b1;
        cnt  <= psm_pkg::DIV_CW'(psm_pkg::DIV_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign div_rsp.done = done;
  assign div_rsp.quo  = quo;
  assign div_rsp.rem  = rem;

endmodule

>>> rtl/psm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psm_back
// Voice table, play set-up and per-frame mixing sequencer.
// ----------------------------------------------------------------------------
module psm_back #(
  parameter int VOICES       = 32,
  parameter int SINE_ENTRIES = 256
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [psm_pkg::SR_W-1:0]   sample_rate,
  input  logic                       q_valid,
  input  psm_pkg::psm_cmd_t          q_data,
  output logic                       q_ready,
  psm_rsp_if.source                  rsp
);

  localparam int VW    = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int LOG2N = $clog2(SINE_ENTRIES);
  localparam int CW    = $clog2(LOG2N);
  localparam int SW    = psm_pkg::SAMPLE_W + 1 + VW;

  typedef logic [SINE_ENTRIES-1:0][psm_pkg::SAMPLE_W-1:0] sine_arr_t;

  function automatic sine_arr_t build_sine();
    sine_arr_t t;
    for (int k = 0; k < SINE_ENTRIES; k++) t[k] = psm_pkg::sine_entry(k, LOG2N);
    return t;
  endfunction

  localparam sine_arr_t SINE_TAB = build_sine();

  psm_pkg::psm_state_t          state;
  psm_pkg::psm_state_t          state_next;
  psm_pkg::psm_cmd_t            cur;
  psm_pkg::psm_voice_t          vmem [VOICES];
  psm_pkg::psm_voice_t          rdata;
  psm_pkg::psm_voice_t          entry;
  psm_pkg::psm_voice_t          mem_wdata;
  logic                         mem_we;
  logic [VW-1:0]                mem_waddr;
  logic [VOICES-1:0]            active;
  logic [VW-1:0]                vidx;
  logic                         last_voice;
  logic [psm_pkg::PER_W-1:0]    period;
  logic [psm_pkg::PROD_W-1:0]   prod;
  logic [psm_pkg::FMUL_W-1:0]   fmul;
  logic [psm_pkg::FRM_W-1:0]    frames;
  logic [psm_pkg::REMAIN_W-1:0] frames_up;
  logic [psm_pkg::PER_W-1:0]    prem;
  logic [psm_pkg::PER_W:0]      ptrial;
  logic                         pfits;
  logic [LOG2N-1:0]             sidx;
  logic [CW-1:0]                cnt;
  logic signed [2*psm_pkg::SAMPLE_W:0] mprod;
  logic signed [SW-1:0]         sum;
  logic signed [psm_pkg::SAMPLE_W-1:0] sat;
  logic                         dropped;
  logic                         out_valid;
  logic signed [psm_pkg::SAMPLE_W-1:0] out_sample;
  logic                         out_dropped;
  logic                         out_load;
  logic                         free_any;
  logic [VW-1:0]                free_idx;
  logic [psm_pkg::PER_W-1:0]    phase_inc;
  psm_pkg::psm_div_req_t        div_req;
  psm_pkg::psm_div_rsp_t        div_rsp;

  psm_div u_div (
    .clk     (clk),
    .rst     (rst),
    .div_req (div_req),
    .div_rsp (div_rsp)
  );

  assign last_voice = (vidx == VW'(VOICES - 1));
  assign ptrial     = {prem, 1'b0};
  assign pfits      = (ptrial >= {1'b0, entry.period});
  assign phase_inc  = entry.phase + 1'b1;
  assign fmul       = psm_pkg::FMUL_W'(prod[psm_pkg::PROD_W-1:psm_pkg::MS_SH]) *
                      psm_pkg::FMUL_W'(psm_pkg::RECIP_125);

  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = VOICES - 1; i >= 0; i--) begin
      if (!active[i]) begin
        free_any = 1'b1;
        free_idx = VW'(i);
      end
    end
  end

  always_comb begin
    if (sum > SW'(32767)) sat = 16'sh7fff;
    else if (sum < -SW'(32768)) sat = 16'sh8000;
    else sat = psm_pkg::SAMPLE_W'(sum);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= psm_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next    = state;
    q_ready       = 1'b0;
    div_req.start = 1'b0;
    div_req.num   = '0;
    div_req.den   = '0;
    mem_we        = 1'b0;
    mem_waddr     = vidx;
    mem_wdata     = entry;
    out_load      = 1'b0;
    case (state)
      psm_pkg::ST_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) state_next = q_data.play ? psm_pkg::ST_P_PER_GO : psm_pkg::ST_T_RD;
      end
      psm_pkg::ST_P_PER_GO: begin
        div_req.start = 1'b1;
        div_req.num   = psm_pkg::DIV_W'(sample_rate);
        div_req.den   = psm_pkg::PER_W'(cur.freq);
        state_next    = psm_pkg::ST_P_PER_W;
      end
      psm_pkg::ST_P_PER_W: begin
        if (div_rsp.done) state_next = psm_pkg::ST_P_MUL;
      end
      psm_pkg::ST_P_MUL: state_next = psm_pkg::ST_P_FRM;
      psm_pkg::ST_P_FRM: state_next = psm_pkg::ST_P_RND_GO;
      psm_pkg::ST_P_RND_GO: begin
        div_req.start = 1'b1;
        div_req.num   = psm_pkg::DIV_W'(frames);
        div_req.den   = period;
        state_next    = psm_pkg::ST_P_RND_W;
      end
      psm_pkg::ST_P_RND_W: begin
        if (div_rsp.done) state_next = psm_pkg::ST_P_WR;
      end
      psm_pkg::ST_P_WR: begin
        mem_we           = free_any;
        mem_waddr        = free_idx;
        mem_wdata.period = period;
        mem_wdata.volume = cur.volume;
        mem_wdata.phase  = '0;
        mem_wdata.remain = frames_up;
        state_next       = psm_pkg::ST_OUT;
      end
      psm_pkg::ST_T_RD: begin
        if (active[vidx]) state_next = psm_pkg::ST_T_LD;
        else if (last_voice) state_next = psm_pkg::ST_OUT;
      end
      psm_pkg::ST_T_LD: state_next = psm_pkg::ST_T_DIV;
      psm_pkg::ST_T_DIV: begin
        if (cnt == CW'(LOG2N - 1)) state_next = psm_pkg::ST_T_MUL;
      end
      psm_pkg::ST_T_MUL: state_next = psm_pkg::ST_T_ACC;
      psm_pkg::ST_T_ACC: begin
        mem_we           = 1'b1;
        mem_wdata.phase  = (phase_inc == entry.period) ? '0 : phase_inc;
        mem_wdata.remain = entry.remain - 1'b1;
        state_next       = last_voice ? psm_pkg::ST_OUT : psm_pkg::ST_T_RD;
      end
      psm_pkg::ST_OUT: begin
        if (!out_valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = psm_pkg::ST_IDLE;
        end
      end
      default: state_next = psm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) vmem[mem_waddr] <= mem_wdata;
    rdata <= vmem[vidx];
  end

  always_ff @(posedge clk) begin
    case (state)
      psm_pkg::ST_IDLE: begin
        cur     <= q_data;
        vidx    <= '0;
        sum     <= '0;
        dropped <= 1'b0;
      end
      psm_pkg::ST_P_PER_W: begin
        period <= (div_rsp.quo == '0) ? psm_pkg::PER_W'(1) : psm_pkg::PER_W'(div_rsp.quo);
      end
      psm_pkg::ST_P_MUL: begin
        prod <= psm_pkg::PROD_W'(cur.duration) * psm_pkg::PROD_W'(sample_rate);
      end
      psm_pkg::ST_P_FRM: frames <= psm_pkg::FRM_W'(fmul >> psm_pkg::RECIP_SH);
      psm_pkg::ST_P_RND_W: begin
        frames_up <= psm_pkg::REMAIN_W'(frames) +
                     ((div_rsp.rem == '0) ? '0 : psm_pkg::REMAIN_W'(period - div_rsp.rem));
      end
      psm_pkg::ST_P_WR: dropped <= !free_any;
      psm_pkg::ST_T_RD: begin
        if (!active[vidx] && !last_voice) vidx <= vidx + 1'b1;
      end
      psm_pkg::ST_T_LD: begin
        entry <= rdata;
        prem  <= rdata.phase;
        cnt   <= '0;
        sidx  <= '0;
      end
      psm_pkg::ST_T_DIV: begin
        prem <= pfits ? psm_pkg::PER_W'(ptrial - {1'b0, entry.period})
                      : psm_pkg::PER_W'(ptrial);
        sidx <= {sidx[LOG2N-2:0], pfits};
        cnt  <= cnt + 1'b1;
      end
      psm_pkg::ST_T_MUL: begin
        mprod <= $signed({1'b0, entry.volume}) * $signed(SINE_TAB[sidx]);
      end
      psm_pkg::ST_T_ACC: begin
        sum <= sum + SW'(mprod >>> psm_pkg::VOL_W);
        if (!last_voice) vidx <= vidx + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == psm_pkg::ST_P_WR && free_any) active[free_idx] <= (frames_up != '0);
      if (state == psm_pkg::ST_T_ACC && entry.remain == psm_pkg::REMAIN_W'(1)) begin
        active[vidx] <= 1'b0;
      end
      if (out_load) out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sample  <= sat;
      out_dropped <= dropped;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.sample       = out_sample;
  assign rsp.play_dropped = out_dropped;

endmodule

>>> rtl/polyphonic_sine_tone_mixer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyphonic_sine_tone_mixer_top
// Sine tone voice table with play set-up and saturating per-frame mixer.
// ----------------------------------------------------------------------------
// A play word takes two passes of the shared restoring divider (sample rate over
// frequency for the period, then the tone length over the period for rounding
// to whole periods); milliseconds become frames by a reciprocal multiplication.
// A tick word walks the voice memory, skipping idle voices and taking each
// sounding voice through its bit-serial phase-to-index step. A stalled result
// adds its wait. A two-word queue takes new words while the back end works and
// while a result waits in the output register. Every word yields one result word.
// ----------------------------------------------------------------------------
module polyphonic_sine_tone_mixer_top #(
  parameter int VOICES       = 32,
  parameter int SINE_ENTRIES = 256
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wr_en,
  input  logic [psm_pkg::SR_W-1:0] cfg_wr_data,
  psm_req_if.sink                  req,
  psm_rsp_if.source                rsp
);

  logic [psm_pkg::SR_W-1:0] sample_rate;
  logic                     q_valid;
  logic                     q_ready;
  psm_pkg::psm_cmd_t        q_data;

  always_ff @(posedge clk) begin
    if (rst) sample_rate <= psm_pkg::SR_RESET;
    else if (cfg_wr_en) sample_rate <= cfg_wr_data;
  end

  psm_front u_front (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_ready (q_ready)
  );

  psm_back #(
    .VOICES       (VOICES),
    .SINE_ENTRIES (SINE_ENTRIES)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .sample_rate (sample_rate),
    .q_valid     (q_valid),
    .q_data      (q_data),
    .q_ready     (q_ready),
    .rsp         (rsp)
  );

  a_drop_silent: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.play_dropped |-> rsp.sample == '0)
    else $error("dropped play carries a sample");

  a_queue_hold: assert property (@(posedge clk) disable iff (rst)
    q_valid && !q_ready |=> q_valid)
    else $error("queued word lost before the back end took it");

  a_queue_take: assert property (@(posedge clk) disable iff (rst)
    q_valid && q_ready |=> !q_ready)
    else $error("back end took a word while busy");

endmodule

>>> tb/polyphonic_sine_tone_mixer_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyphonic_sine_tone_mixer_top_test
// Self-checking bench for the tone mixer. A queue-fed driver sends play and
// tick words with random idle bursts. A voice-table model predicts each mixed
// sample and each drop flag. A monitor with random stalls checks the response
// words in order. The sample rate is changed between drained phases.
// ----------------------------------------------------------------------------
module polyphonic_sine_tone_mixer_top_test;

  localparam int NV   = 32;
  localparam int NLUT = 256;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic                       cmd;
    logic [psm_pkg::FREQ_W-1:0] freq;
    logic [psm_pkg::VOL_W-1:0]  vol;
    logic [psm_pkg::DUR_W-1:0]  dur;
  } tone_word_t;

  typedef struct {
    logic signed [psm_pkg::SAMPLE_W-1:0] sample;
    logic                                dropped;
  } mix_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [psm_pkg::SR_W-1:0] cfg_wr_data = '0;

  psm_req_if req ();
  psm_rsp_if rsp ();

  polyphonic_sine_tone_mixer_top uut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .req(req), .rsp(rsp)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // model state
  logic signed [15:0]       wave_lut [NLUT];
  logic [psm_pkg::SR_W-1:0] rate_model;
  logic                     v_on [NV];
  logic [31:0]              v_start [NV];
  logic [31:0]              v_end [NV];
  logic [31:0]              v_per [NV];
  logic [15:0]              v_vol [NV];
  logic [31:0]              frame_no;

  tone_word_t pending_words[$];
  mix_out_t   samples_due[$];
  int         mismatches = 0;
  bit         quiet = 0;
  int         long_left = 3;

  function automatic logic [63:0] sin_mag(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    longint      s;
    x2 = (x * x) >> 30;
    term = x;
    s = longint'(x);
    for (int i = 1; i <= 8; i++) begin
      term = ((term * x2) >> 30) / 64'((2 * i) * (2 * i + 1));
      if (i % 2 == 1) s -= longint'(term);
      else s += longint'(term);
    end
    if (s < 0) s = 0;
    if (s > 64'd1073741824) s = 64'd1073741824;
    return 64'(s);
  endfunction

  task automatic fill_wave_lut();
    logic [63:0] q, r, mag;
    for (int k = 0; k < NLUT; k++) begin
      q = (k * 4) / NLUT;
      r = (k * 4) % NLUT;
      if (q[0]) r = NLUT - r;
      mag = (sin_mag((r * 64'd3373259426) / (2 * NLUT)) * 64'd32767 + 64'd536870912) >> 30;
      wave_lut[k] = (q >= 2) ? -16'(mag) : 16'(mag);
    end
  endtask

  function automatic mix_out_t mix_word(input tone_word_t w);
    mix_out_t o;
    logic [63:0] per, frames;
    logic [31:0] f, off, len, nxt;
    longint sum, p;
    logic [63:0] idx;
    o.sample = '0;
    o.dropped = 1'b0;
    if (w.cmd) begin
      f = (w.freq == 0) ? 32'd1 : 32'(w.freq);
      per = rate_model / f;
      if (per == 0) per = 1;
      frames = (64'(w.dur) * rate_model) / 1000;
      frames = ((frames + per - 1) / per) * per;
      o.dropped = 1'b1;
      for (int v = 0; v < NV; v++) begin
        if (!v_on[v]) begin
          v_per[v] = 32'(per);
          v_vol[v] = w.vol;
          v_start[v] = frame_no;
          v_end[v] = frame_no + 32'(frames);
          v_on[v] = (frames != 0);
          o.dropped = 1'b0;
          break;
        end
      end
    end else begin
      sum = 0;
      nxt = frame_no + 1;
      for (int v = 0; v < NV; v++) begin
        if (!v_on[v]) continue;
        off = frame_no - v_start[v];
        len = v_end[v] - v_start[v];
        if (off < len) begin
          idx = (64'(off % v_per[v]) * NLUT) / v_per[v];
          if (idx >= NLUT) idx = NLUT - 1;
          p = longint'(v_vol[v]) * longint'(wave_lut[idx]);
          if (p >= 0) sum += p / 65536;
          else sum -= ((-p) + 65535) / 65536;
        end
        if (32'(nxt - v_start[v]) >= len) v_on[v] = 1'b0;
      end
      frame_no = nxt;
      if (sum > 32767) sum = 32767;
      if (sum < -32768) sum = -32768;
      o.sample = 16'(sum);
    end
    return o;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // driver
  tone_word_t cur;
  int send_gap = 0;
  int watchdog = 0;

  always @(posedge clk) begin
    bit nv;
    if (!rst) begin
      if (req.valid && req.ready) samples_due.push_back(mix_word(cur));
      nv = req.valid && !req.ready;
      if (!nv) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_words.size() > 0) begin
          cur = pending_words.pop_front();
          req.cmd <= cur.cmd;
          req.frequency <= cur.freq;
          req.volume <= cur.vol;
          req.duration_ms <= cur.dur;
          nv = 1'b1;
          if (!quiet && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 14);
        end
      end
      req.valid <= nv;
    end
  end

  // monitor
  int sink_gap = 0;

  always @(posedge clk) begin
    mix_out_t e;
    if (!rst) begin
      if (rsp.valid && rsp.ready) begin
        if (samples_due.size() == 0) begin
          report("unexpected word", rsp.sample, 0);
        end else begin
          e = samples_due.pop_front();
          if (rsp.sample !== e.sample) report("sample", rsp.sample, e.sample);
          if (rsp.play_dropped !== e.dropped) report("play_dropped", rsp.play_dropped, e.dropped);
        end
      end
      if (sink_gap > 0) begin
        sink_gap--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
        if (!quiet && $urandom_range(0, 7) == 0) sink_gap = $urandom_range(1, 14);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) watchdog <= 0;
    else watchdog <= watchdog + 1;
    if (watchdog >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic push(input logic c, input int f, input int vol, input int d);
    tone_word_t w;
    w.cmd = c;
    w.freq = psm_pkg::FREQ_W'(f);
    w.vol = psm_pkg::VOL_W'(vol);
    w.dur = psm_pkg::DUR_W'(d);
    pending_words.push_back(w);
  endtask

  task automatic ticks(input int n);
    repeat (n) push(1'b0, $urandom, $urandom, $urandom);
  endtask

  task automatic random_mix(input int n);
    int d, r;
    repeat (n) begin
      if ($urandom_range(0, 2) == 0) begin
        r = $urandom_range(0, 99);
        if (r < 90) d = $urandom_range(0, 2);
        else if (r < 97) d = $urandom_range(0, 15);
        else if (long_left > 0) begin
          long_left--;
          d = $urandom_range(16, 65535);
        end else d = 1;
        push(1'b1, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 32767)
                                                : $urandom_range(20, 4000),
             $urandom_range(0, 65535), d);
      end else begin
        ticks(1);
      end
    end
  endtask

  task automatic drain_and_set_rate(input logic [psm_pkg::SR_W-1:0] sr);
    do @(posedge clk);
    while (pending_words.size() != 0 || req.valid || samples_due.size() != 0);
    repeat (400) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= sr;
    rate_model = sr;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    req.valid = 1'b0;
    req.cmd = 1'b0;
    req.frequency = '0;
    req.volume = '0;
    req.duration_ms = '0;
    rsp.ready = 1'b0;
    fill_wave_lut();
    rate_model = psm_pkg::SR_RESET;
    frame_no = '0;
    for (int v = 0; v < NV; v++) begin
      v_on[v] = 1'b0;
      v_start[v] = '0;
      v_end[v] = '0;
      v_per[v] = 1;
      v_vol[v] = '0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    push(1'b1, 0, 65535, 1);
    push(1'b1, 32767, 65535, 2);
    push(1'b1, 1000, 40000, 0);
    push(1'b1, 1000, 0, 3);
    push(1'b1, 1000, 65535, 2);
    push(1'b1, 1000, 65535, 2);
    push(1'b1, 1000, 65535, 2);
    ticks(10);
    push(1'b1, 700, 65535, 65535);
    ticks(3);
    random_mix(200);

    drain_and_set_rate(psm_pkg::SR_W'(8000));
    push(1'b1, 24000, 65535, 5);
    push(1'b1, 16384, 65535, 3);
    ticks(6);
    random_mix(150);

    drain_and_set_rate(psm_pkg::SR_W'(192000));
    random_mix(150);

    drain_and_set_rate(psm_pkg::SR_W'(0));
    push(1'b1, 440, 30000, 100);
    random_mix(20);

    drain_and_set_rate(psm_pkg::SR_W'(44100));
    repeat (34) push(1'b1, $urandom_range(50, 3000), $urandom_range(0, 65535), 1);
    ticks(60);
    drain_and_set_rate(psm_pkg::SR_W'(48000));
    quiet = 1;
    random_mix(150);

    do @(posedge clk);
    while (pending_words.size() != 0 || req.valid || samples_due.size() != 0);
    repeat (500) @(posedge clk);
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> filelist.f
rtl/psm_pkg.sv
rtl/psm_if.sv
rtl/psm_front.sv
rtl/psm_div.sv
rtl/psm_back.sv
rtl/polyphonic_sine_tone_mixer_top.sv
tb/polyphonic_sine_tone_mixer_top_test.sv
